// File: rtl/m4rt_pkg.sv
// ----------------------------------------------------------------------------
// m4rt_pkg
// Shared types and constants for the 4x4 row transform unit: item kinds,
// request codes, the bundle that travels down the cell chain and row writes.
// ----------------------------------------------------------------------------
package m4rt_pkg;

  localparam int DATA_W    = 32;
  localparam int VEC_W     = DATA_W + 1;      // negated translation needs one more bit
  localparam int PROD_W    = VEC_W + DATA_W;
  localparam int SUM_W     = PROD_W + 1;      // four products, exact
  localparam int NUM_LANES = 4;

  localparam logic [1:0] LAST_ROW = 2'(NUM_LANES - 1);

  // request codes on in_req_type
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_MUL  = 2'd1;
  localparam logic [1:0] REQ_INV  = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_MUL,
    KIND_ROW,
    KIND_TINV
  } kind_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_INJ,
    SEQ_WAIT
  } seq_state_t;

  typedef logic [DATA_W-1:0] word_t;
  typedef word_t [NUM_LANES-1:0] row_t;

  typedef struct packed {
    kind_t                               kind;
    logic [1:0]                          row;
    logic [NUM_LANES-1:0][VEC_W-1:0]     vec;
    logic [NUM_LANES-1:0][SUM_W-1:0]     acc;
  } item_t;

  typedef struct packed {
    logic en;
    row_t data;
  } row_wr_t;

endpackage

// File: rtl/matrix4_row_transform_unit.sv
// ----------------------------------------------------------------------------
// matrix4_row_transform_unit
// Holds a 4x4 Q16.16 matrix in a chain of four row cells. Loads write a row,
// multiplies stream a row vector through the chain, an inverse replaces the
// matrix by its rigid-transform inverse and emits the four new rows.
//
//   channel  dir  handshake             payload
//   in_*     in   in_valid / in_stall   req_type, row_index, elem_0..elem_3
//   out_*    out  out_valid / out_stall out_0..out_3, out_row, out_last,
//                                       out_saturated
//
// loads and multiplies are taken one per cycle while in_stall is low; a multiply
// result passes two stages per cell and one round stage into the output register
// an inverse waits until the cell chain is empty, then stalls the input while
// its three rows and the translation row pass down the chain
// reset clears the matrix to zeros
// a stalled output register holds; earlier stages keep closing up their gaps
// ----------------------------------------------------------------------------
module matrix4_row_transform_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_req_type,
  input  logic [1:0]                          in_row_index,
  input  logic signed [m4rt_pkg::DATA_W-1:0]  in_elem_0,
  input  logic signed [m4rt_pkg::DATA_W-1:0]  in_elem_1,
  input  logic signed [m4rt_pkg::DATA_W-1:0]  in_elem_2,
  input  logic signed [m4rt_pkg::DATA_W-1:0]  in_elem_3,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [m4rt_pkg::DATA_W-1:0]  out_0,
  output logic signed [m4rt_pkg::DATA_W-1:0]  out_1,
  output logic signed [m4rt_pkg::DATA_W-1:0]  out_2,
  output logic signed [m4rt_pkg::DATA_W-1:0]  out_3,
  output logic [1:0]                          out_row,
  output logic                                out_last,
  output logic                                out_saturated
);
  import m4rt_pkg::*;

  item_t                 lnk_item  [NUM_LANES+1];
  logic                  lnk_valid [NUM_LANES+1];
  logic                  lnk_ready [NUM_LANES+1];
  row_t                  rows      [NUM_LANES];
  row_wr_t               ext_wr    [NUM_LANES];
  logic [NUM_LANES-1:0]  cell_busy;
  row_wr_t               wb;

  seq_state_t            state_r, state_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  xpose;
  logic                  chain_busy;
  word_t                 in_elem [NUM_LANES];
  item_t                 in_item, inj_item;

  assign chain_busy = |cell_busy;

  assign in_elem[0] = in_elem_0;
  assign in_elem[1] = in_elem_1;
  assign in_elem[2] = in_elem_2;
  assign in_elem[3] = in_elem_3;

  always_comb begin
    in_item.kind = (in_req_type == REQ_MUL) ? KIND_MUL : KIND_LOAD;
    in_item.row  = (in_req_type == REQ_MUL) ? 2'b00 : in_row_index;
    in_item.acc  = '0;
    for (int c = 0; c < NUM_LANES; c++) begin
      in_item.vec[c] = {in_elem[c][DATA_W-1], in_elem[c]};
    end
  end

  // rows 0..2 of the inverse are already in the cells; the translation row
  // is the negated old row 3 times that transposed block
  always_comb begin
    inj_item.kind = (cnt_r == LAST_ROW) ? KIND_TINV : KIND_ROW;
    inj_item.row  = cnt_r;
    inj_item.acc  = '0;
    for (int c = 0; c < NUM_LANES; c++) begin
      if (cnt_r == LAST_ROW) begin
        if (c < NUM_LANES - 1) begin
          inj_item.vec[c] = VEC_W'(0) - {rows[NUM_LANES-1][c][DATA_W-1], rows[NUM_LANES-1][c]};
        end else begin
          inj_item.vec[c] = '0;
        end
      end else begin
        inj_item.vec[c] = {rows[cnt_r][c][DATA_W-1], rows[cnt_r][c]};
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      SEQ_IDLE: begin
        cnt_nxt = '0;
        if (in_valid && !in_stall && in_req_type == REQ_INV) begin
          state_nxt = SEQ_INJ;
        end
      end
      SEQ_INJ: begin
        if (lnk_ready[0]) begin
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == LAST_ROW) begin
            state_nxt = SEQ_WAIT;
          end
        end
      end
      SEQ_WAIT: begin
        if (wb.en) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall     = 1'b1;
    lnk_valid[0] = 1'b0;
    lnk_item[0]  = in_item;
    xpose        = 1'b0;
    case (state_r)
      SEQ_IDLE: begin
        in_stall     = !lnk_ready[0] || (in_req_type == REQ_INV && chain_busy);
        lnk_valid[0] = in_valid && !in_stall &&
                       (in_req_type == REQ_LOAD || in_req_type == REQ_MUL);
        xpose        = in_valid && !in_stall && in_req_type == REQ_INV;
      end
      SEQ_INJ: begin
        lnk_valid[0] = 1'b1;
        lnk_item[0]  = inj_item;
      end
      SEQ_WAIT: begin
        in_stall = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // transpose of the upper 3x3 block into rows 0..2, last column zero
  always_comb begin
    for (int k = 0; k < NUM_LANES - 1; k++) begin
      ext_wr[k].en = xpose;
      for (int c = 0; c < NUM_LANES; c++) begin
        ext_wr[k].data[c] = (c < NUM_LANES - 1) ? rows[c][k] : '0;
      end
    end
    ext_wr[NUM_LANES-1] = wb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_cell
    m4rt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .row_id   (2'(k)),
      .up_valid (lnk_valid[k]),
      .up_ready (lnk_ready[k]),
      .up_item  (lnk_item[k]),
      .dn_valid (lnk_valid[k+1]),
      .dn_ready (lnk_ready[k+1]),
      .dn_item  (lnk_item[k+1]),
      .ext_wr   (ext_wr[k]),
      .row_q    (rows[k]),
      .busy     (cell_busy[k])
    );
  end

  m4rt_round #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (lnk_valid[NUM_LANES]),
    .up_ready      (lnk_ready[NUM_LANES]),
    .up_item       (lnk_item[NUM_LANES]),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_0         (out_0),
    .out_1         (out_1),
    .out_2         (out_2),
    .out_3         (out_3),
    .out_row       (out_row),
    .out_last      (out_last),
    .out_saturated (out_saturated),
    .wb            (wb)
  );

endmodule

// File: rtl/m4rt_cell.sv
// ----------------------------------------------------------------------------
// m4rt_cell
// One cell of the chain: holds one matrix row, multiplies its vector element
// by that row, then adds the four products into the running sums.
// ----------------------------------------------------------------------------
module m4rt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        row_id,
  input  logic              up_valid,
  output logic              up_ready,
  input  m4rt_pkg::item_t   up_item,
  output logic              dn_valid,
  input  logic              dn_ready,
  output m4rt_pkg::item_t   dn_item,
  input  m4rt_pkg::row_wr_t ext_wr,
  output m4rt_pkg::row_t    row_q,
  output logic              busy
);
  import m4rt_pkg::*;

  logic                                a_v_r;
  item_t                               a_item_r;
  logic [NUM_LANES-1:0][PROD_W-1:0]    prod_r, prod_nxt;
  logic                                b_v_r;
  item_t                               b_item_r, b_item_nxt;
  row_t                                row_r, row_nxt;
  logic                                b_ready;
  logic                                take;
  logic signed [VEC_W-1:0]             mul_a;

  assign b_ready  = !b_v_r || dn_ready;
  assign up_ready = !a_v_r || b_ready;
  assign take     = up_valid && up_ready;
  assign mul_a    = up_item.vec[row_id];

  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      prod_nxt[c] = mul_a * $signed(row_r[c]);
    end
  end

  // loads write their row as they enter the cell, in order with the multiplies
  always_comb begin
    row_nxt = row_r;
    if (ext_wr.en) begin
      row_nxt = ext_wr.data;
    end else if (take && up_item.kind == KIND_LOAD && up_item.row == row_id) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        row_nxt[c] = up_item.vec[c][DATA_W-1:0];
      end
    end
  end

  always_comb begin
    b_item_nxt = a_item_r;
    for (int c = 0; c < NUM_LANES; c++) begin
      b_item_nxt.acc[c] = a_item_r.acc[c] + {prod_r[c][PROD_W-1], prod_r[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      row_r <= '0;
    end else begin
      if (up_ready) begin
        a_v_r <= up_valid;
      end
      if (b_ready) begin
        b_v_r <= a_v_r;
      end
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_item_r <= up_item;
      prod_r   <= prod_nxt;
    end
    if (b_ready && a_v_r) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign dn_valid = b_v_r;
  assign dn_item  = b_item_r;
  assign row_q    = row_r;
  assign busy     = a_v_r || b_v_r;

endmodule

// File: rtl/m4rt_round.sv
// ----------------------------------------------------------------------------
// m4rt_round
// Output stage: rounds and saturates the chain sums, formats the result row
// and holds it in the output register. Hands the translation row back to the
// last cell when an inverse finishes.
// ----------------------------------------------------------------------------
module m4rt_round #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  m4rt_pkg::item_t              up_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [m4rt_pkg::DATA_W-1:0]  out_0,
  output logic [m4rt_pkg::DATA_W-1:0]  out_1,
  output logic [m4rt_pkg::DATA_W-1:0]  out_2,
  output logic [m4rt_pkg::DATA_W-1:0]  out_3,
  output logic [1:0]                   out_row,
  output logic                         out_last,
  output logic                         out_saturated,
  output m4rt_pkg::row_wr_t            wb
);
  import m4rt_pkg::*;

  localparam logic [SUM_W-1:0] HALF    = SUM_W'(1) << (FRAC_BITS - 1);
  localparam word_t            ONE     = DATA_W'(1) << FRAC_BITS;
  localparam word_t            MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t            MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  logic                                out_valid_r;
  row_t                                res_r, res_nxt;
  logic [1:0]                          row_r;
  logic                                last_r, last_nxt;
  logic                                sat_r, sat_nxt;
  logic [NUM_LANES-1:0][SUM_W-1:0]     rnd, shf;
  logic [NUM_LANES-1:0]                ovf;
  row_t                                rval;
  logic                                tail_ready;
  logic                                cap;

  assign tail_ready = !out_valid_r || !out_stall;
  // loads end here and need no room in the output register
  assign up_ready   = tail_ready || up_item.kind == KIND_LOAD;
  assign cap        = up_valid && tail_ready && up_item.kind != KIND_LOAD;

  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      rnd[c]  = up_item.acc[c] + HALF;
      shf[c]  = $signed(rnd[c]) >>> FRAC_BITS;
      ovf[c]  = !((&shf[c][SUM_W-1:DATA_W-1]) || !(|shf[c][SUM_W-1:DATA_W-1]));
      rval[c] = ovf[c] ? (shf[c][SUM_W-1] ? MIN_NEG : MAX_POS) : shf[c][DATA_W-1:0];
    end
  end

  always_comb begin
    res_nxt  = rval;
    last_nxt = 1'b1;
    sat_nxt  = |ovf;
    case (up_item.kind)
      KIND_MUL: begin
        res_nxt = rval;
      end
      KIND_TINV: begin
        res_nxt[NUM_LANES-1] = ONE;
        sat_nxt              = |ovf[NUM_LANES-2:0];
      end
      KIND_ROW: begin
        for (int c = 0; c < NUM_LANES; c++) begin
          res_nxt[c] = up_item.vec[c][DATA_W-1:0];
        end
        last_nxt = 1'b0;
        sat_nxt  = 1'b0;
      end
      default: begin
        res_nxt  = '0;
        last_nxt = 1'b0;
        sat_nxt  = 1'b0;
      end
    endcase
  end

  assign wb.en   = cap && up_item.kind == KIND_TINV;
  assign wb.data = res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tail_ready) begin
      out_valid_r <= cap;
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      res_r  <= res_nxt;
      row_r  <= up_item.row;
      last_r <= last_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_0         = res_r[0];
  assign out_1         = res_r[1];
  assign out_2         = res_r[2];
  assign out_3         = res_r[3];
  assign out_row       = row_r;
  assign out_last      = last_r;
  assign out_saturated = sat_r;

endmodule

// File: rtl/m4rt_checker.sv
// ----------------------------------------------------------------------------
// m4rt_checker
// Port-level checks for the row transform unit, bound to the top level.
// ----------------------------------------------------------------------------
module m4rt_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [1:0]                          in_req_type,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [m4rt_pkg::DATA_W-1:0]  out_3,
  input logic [1:0]                          out_row,
  input logic                                out_last,
  input logic                                out_saturated
);
  import m4rt_pkg::*;

  localparam word_t ONE = DATA_W'(1) << FRAC_BITS;

  // a result held back by the sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // rows that do not close a run are never row 3 and never flagged saturated
  a_mid_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_row != LAST_ROW && !out_saturated)
    else $error("inner inverse row is row 3 or flagged saturated");

  a_trans_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row == LAST_ROW |-> out_last && out_3 == ONE)
    else $error("translation row not last or corner not one");

  // an inverse transfer blocks the next item while its rows are produced
  a_inv_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_req_type == REQ_INV |=> in_stall)
    else $error("input taken straight after an inverse");

endmodule

bind matrix4_row_transform_unit m4rt_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_m4rt_checker (.*);

// File: tb/tb_matrix4_row_transform_unit.sv
// ----------------------------------------------------------------------------
// tb_matrix4_row_transform_unit
// Self-checking bench for the 4x4 row transform unit. A scoreboard class keeps
// its own copy of the stored matrix and predicts every result row: exact dot
// products rounded to nearest and clipped, and the rigid inverse with its
// translation row. Directed rows hit the extremes, rounding ties and clipping,
// then random load/multiply/inverse sequences run with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_matrix4_row_transform_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import m4rt_pkg::*;

  localparam int FRAC         = 16;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int TOTAL_ITEMS  = 160;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 40;

  // request code the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
  localparam logic signed [31:0] MAX_Q = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_Q = 32'sh8000_0000;
  localparam logic signed [31:0] HALF_LSB = 32'sh0000_8000;

  typedef struct packed {
    logic [3:0][31:0] el;
    logic [1:0]       row;
    logic             last;
    logic             sat;
  } emitted_row_t;

  class matrix_row_predictor;
    typedef logic signed [67:0] wide_t;

    logic signed [31:0] mat [4][4];
    emitted_row_t rows_due[$];
    int mismatches, rows_seen, clipped_seen;
    int loads, muls, invs, ignored;

    function new();
      foreach (mat[i, j]) mat[i][j] = '0;
      mismatches = 0;
      rows_seen = 0;
      clipped_seen = 0;
      loads = 0;
      muls = 0;
      invs = 0;
      ignored = 0;
    endfunction

    // round to nearest, ties upwards, then clip to 32 bits
    function logic signed [31:0] round_clip(input wide_t s, inout bit clip);
      wide_t r;
      r = (s + (wide_t'(1) <<< (FRAC - 1))) >>> FRAC;
      if (r > wide_t'(MAX_Q)) begin
        clip = 1'b1;
        return MAX_Q;
      end
      if (r < wide_t'(MIN_Q)) begin
        clip = 1'b1;
        return MIN_Q;
      end
      return r[31:0];
    endfunction

    function void push_row(input logic signed [31:0] res [4], input logic [1:0] row,
                           input logic last, input logic sat);
      emitted_row_t r;
      for (int i = 0; i < 4; i++) r.el[i] = res[i];
      r.row  = row;
      r.last = last;
      r.sat  = sat;
      rows_due.push_back(r);
    endfunction

    function void note_request(input logic [1:0] req, input logic [1:0] row,
                               input logic signed [31:0] e0, input logic signed [31:0] e1,
                               input logic signed [31:0] e2, input logic signed [31:0] e3);
      logic signed [31:0] v [4];
      logic signed [31:0] nm [4][4];
      logic signed [31:0] res [4];
      wide_t acc;
      bit clip;
      v = '{e0, e1, e2, e3};
      clip = 1'b0;
      case (req)
        REQ_LOAD: begin
          for (int i = 0; i < 4; i++) mat[row][i] = v[i];
          loads++;
        end
        REQ_MUL: begin
          for (int c = 0; c < 4; c++) begin
            acc = '0;
            for (int i = 0; i < 4; i++) acc += wide_t'(v[i]) * wide_t'(mat[i][c]);
            res[c] = round_clip(acc, clip);
          end
          push_row(res, 2'd0, 1'b1, clip);
          muls++;
        end
        REQ_INV: begin
          for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) nm[i][c] = mat[c][i];
            nm[i][3] = '0;
          end
          // translation from the exact negated sum, rounded once
          for (int c = 0; c < 3; c++) begin
            acc = '0;
            for (int i = 0; i < 3; i++) acc += -wide_t'(mat[3][i]) * wide_t'(mat[c][i]);
            nm[3][c] = round_clip(acc, clip);
          end
          nm[3][3] = ONE_Q;
          mat = nm;
          for (int i = 0; i < 4; i++) begin
            for (int c = 0; c < 4; c++) res[c] = nm[i][c];
            push_row(res, 2'(i), i == 3, (i == 3) && clip);
          end
          invs++;
        end
        default: ignored++;
      endcase
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      // keep the log readable when something breaks badly
      if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_row(input logic [3:0][31:0] el, input logic [1:0] row,
                   input logic last, input logic sat);
      emitted_row_t want;
      if (rows_due.size() == 0) begin
        report_mismatch($sformatf("result row %0d with nothing outstanding", row));
        return;
      end
      want = rows_due.pop_front();
      rows_seen++;
      if (sat) clipped_seen++;
      for (int i = 0; i < 4; i++) begin
        if (el[i] !== want.el[i])
          report_mismatch($sformatf("row %0d elem %0d: got %0d, want %0d", want.row, i,
                                    $signed(el[i]), $signed(want.el[i])));
      end
      if (row !== want.row)
        report_mismatch($sformatf("out_row: got %0d, want %0d", row, want.row));
      if (last !== want.last)
        report_mismatch($sformatf("row %0d out_last: got %b, want %b", want.row, last,
                                  want.last));
      if (sat !== want.sat)
        report_mismatch($sformatf("row %0d out_saturated: got %b, want %b", want.row, sat,
                                  want.sat));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_req_type;
  logic [1:0] in_row_index;
  logic signed [31:0] in_elem_0, in_elem_1, in_elem_2, in_elem_3;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_0, out_1, out_2, out_3;
  logic [1:0] out_row;
  logic out_last;
  logic out_saturated;

  matrix_row_predictor sb = new();

  bit calm;
  bit hold_request;
  int cycle_count;
  int items_sent;

  matrix4_row_transform_unit #(.FRAC_BITS(FRAC)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_row_index (in_row_index),
    .in_elem_0    (in_elem_0),
    .in_elem_1    (in_elem_1),
    .in_elem_2    (in_elem_2),
    .in_elem_3    (in_elem_3),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_0        (out_0),
    .out_1        (out_1),
    .out_2        (out_2),
    .out_3        (out_3),
    .out_row      (out_row),
    .out_last     (out_last),
    .out_saturated(out_saturated)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d rows outstanding", cycle_count,
               sb.rows_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // transfers are seen with the values that stood before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_request(in_req_type, in_row_index, in_elem_0, in_elem_1, in_elem_2,
                        in_elem_3);
      if (out_valid && !out_stall)
        sb.check_row({out_3, out_2, out_1, out_0}, out_row, out_last, out_saturated);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] rand_elem();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
      5, 6, 7:       return $urandom;
      8: begin
        case ($urandom_range(0, 2))
          0:       return MAX_Q;
          1:       return MIN_Q;
          default: return 32'sh0;
        endcase
      end
      default: return $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
    endcase
  endfunction

  // receiver: random stalls, or one long hold-off when asked
  initial begin : out_stall_gen
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
      end else begin
        n = pick_gap() + 1;
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_row(input logic [1:0] req, input logic [1:0] row,
                          input logic signed [31:0] e0, input logic signed [31:0] e1,
                          input logic signed [31:0] e2, input logic signed [31:0] e3);
    int g;
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_row_index <= row;
    in_elem_0    <= e0;
    in_elem_1    <= e1;
    in_elem_2    <= e2;
    in_elem_3    <= e3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (req != REQ_UNUSED) items_sent++;
    @(negedge clk);
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send_rand(input logic [1:0] req, input logic [1:0] row);
    send_row(req, row, rand_elem(), rand_elem(), rand_elem(), rand_elem());
  endtask

  task automatic wait_results_in();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.rows_due.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int scen, m;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = REQ_LOAD;
    in_row_index = 2'd0;
    in_elem_0    = '0;
    in_elem_1    = '0;
    in_elem_2    = '0;
    in_elem_3    = '0;
    calm         = 1'b1;
    hold_request = 1'b0;
    items_sent   = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // matrix straight out of reset, then an ignored request
    send_row(REQ_MUL, 2'd0, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 4 * ONE_Q);
    send_row(REQ_UNUSED, 2'd3, -1, -1, -1, -1);
    // identity passes the extremes through unchanged
    send_row(REQ_LOAD, 2'd0, ONE_Q, 0, 0, 0);
    send_row(REQ_LOAD, 2'd1, 0, ONE_Q, 0, 0);
    send_row(REQ_LOAD, 2'd2, 0, 0, ONE_Q, 0);
    send_row(REQ_LOAD, 2'd3, 0, 0, 0, ONE_Q);
    send_row(REQ_MUL, 2'd0, MAX_Q, MIN_Q, 32'sd1, -32'sd1);
    send_row(REQ_INV, 2'd0, 0, 0, 0, 0);
    // clipping in both directions
    send_row(REQ_LOAD, 2'd0, MAX_Q, MAX_Q, MAX_Q, MAX_Q);
    send_row(REQ_LOAD, 2'd1, MAX_Q, MAX_Q, MAX_Q, MAX_Q);
    send_row(REQ_MUL, 2'd0, MAX_Q, MAX_Q, 0, 0);
    send_row(REQ_MUL, 2'd0, MIN_Q, MIN_Q, 0, 0);
    // exact half an lsb: ties go upwards
    send_row(REQ_LOAD, 2'd2, HALF_LSB, HALF_LSB, HALF_LSB, HALF_LSB);
    send_row(REQ_MUL, 2'd0, 0, 0, 32'sd1, 0);
    send_row(REQ_MUL, 2'd0, 0, 0, -32'sd1, 0);
    // rotation about z with a translation, inverted and applied
    send_row(REQ_LOAD, 2'd0, 0, ONE_Q, 0, 0);
    send_row(REQ_LOAD, 2'd1, -ONE_Q, 0, 0, 0);
    send_row(REQ_LOAD, 2'd2, 0, 0, ONE_Q, 0);
    send_row(REQ_LOAD, 2'd3, 3 * ONE_Q, -5 * ONE_Q, 2 * ONE_Q, ONE_Q);
    send_row(REQ_INV, 2'd1, 0, 0, 0, 0);
    send_row(REQ_MUL, 2'd0, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, ONE_Q);
    // translation row that clips
    send_row(REQ_LOAD, 2'd0, MAX_Q, MAX_Q, MAX_Q, 0);
    send_row(REQ_LOAD, 2'd1, MAX_Q, MAX_Q, MAX_Q, 0);
    send_row(REQ_LOAD, 2'd2, MAX_Q, MAX_Q, MAX_Q, 0);
    send_row(REQ_LOAD, 2'd3, MIN_Q, MIN_Q, MIN_Q, ONE_Q);
    send_row(REQ_INV, 2'd2, 0, 0, 0, 0);

    // long receiver hold-off while rows keep coming, so the block backs up
    wait_results_in();
    hold_request = 1'b1;
    for (int i = 0; i < 30; i++) send_rand(REQ_MUL, 2'(i));
    wait_results_in();
    calm = 1'b0;

    while (items_sent < TOTAL_ITEMS) begin
      scen = $urandom_range(0, 9);
      if (scen <= 3) begin
        for (int r = 0; r < 4; r++) send_rand(REQ_LOAD, 2'(r));
        m = $urandom_range(1, 6);
        repeat (m) send_rand(REQ_MUL, 2'($urandom_range(0, 3)));
      end else if (scen <= 5) begin
        // rigid-shaped matrix: zero last column, one in the corner
        for (int r = 0; r < 3; r++)
          send_row(REQ_LOAD, 2'(r), rand_elem(), rand_elem(), rand_elem(), 0);
        send_row(REQ_LOAD, 2'd3, rand_elem(), rand_elem(), rand_elem(), ONE_Q);
        send_rand(REQ_INV, 2'($urandom_range(0, 3)));
        m = $urandom_range(1, 3);
        repeat (m) send_rand(REQ_MUL, 2'($urandom_range(0, 3)));
      end else if (scen == 6) begin
        send_rand(REQ_INV, 2'($urandom_range(0, 3)));
        send_rand(REQ_MUL, 2'($urandom_range(0, 3)));
      end else if (scen <= 8) begin
        send_row(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom, $urandom,
                 $urandom, $urandom);
      end else begin
        // now and then a stretch with no idling on either side
        calm = ~calm;
        if ($urandom_range(0, 1)) wait_results_in();
      end
    end
    calm = 1'b0;

    wait_results_in();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d loads, %0d multiplies, %0d inverses, %0d ignored requests",
             sb.loads, sb.muls, sb.invs, sb.ignored);
    $display("checked %0d result rows, %0d of them clipped, %0d mismatches",
             sb.rows_seen, sb.clipped_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/m4rt_pkg.sv
rtl/m4rt_cell.sv
rtl/m4rt_round.sv
rtl/matrix4_row_transform_unit.sv
rtl/m4rt_checker.sv
tb/tb_matrix4_row_transform_unit.sv
